// File: src/raster_row_run_length_decoder_macros.svh
// ----------------------------------------------------------------------------
// raster_row_run_length_decoder_macros
// assertion helpers for the raster row run-length decoder
// ----------------------------------------------------------------------------
`ifndef RASTER_ROW_RUN_LENGTH_DECODER_MACROS_SVH
`define RASTER_ROW_RUN_LENGTH_DECODER_MACROS_SVH

// same-cycle implication
`define RRRLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrrld assertion failed");

// next-cycle implication
`define RRRLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrrld assertion failed");

`endif

// File: src/rrrld_pkg.sv
// ----------------------------------------------------------------------------
// rrrld_pkg
// types and constants shared by the raster row run-length decoder
// ----------------------------------------------------------------------------
package rrrld_pkg;

  localparam int unsigned ColumnBits = 16;
  localparam int unsigned FifoDepth  = 4;

  typedef enum logic [1:0] {
    PhSkip = 2'd0,
    PhRuns = 2'd1,
    PhDone = 2'd2
  } phase_e;

  typedef enum logic {
    CfgColourDepth = 1'b0,
    CfgColumnLimit = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_end;
  } in_item_t;

  typedef struct packed {
    logic [6:0]            run_colour;
    logic [ColumnBits-1:0] run_start;
    logic [ColumnBits-1:0] run_length;
    logic                  is_fill;
    logic                  row_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0]            colour_depth;
    logic [ColumnBits-1:0] column_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } res_bundle_t;

endpackage

// File: src/rrrld_decode.sv
// ----------------------------------------------------------------------------
// rrrld_decode
// row state and single-pass decode of one byte into up to two runs
// ----------------------------------------------------------------------------
module rrrld_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  rrrld_pkg::in_item_t   item_i,
  input  rrrld_pkg::cfg_t       cfg_i,
  output rrrld_pkg::res_bundle_t res_o
);

  localparam int unsigned CB = rrrld_pkg::ColumnBits;

  rrrld_pkg::phase_e phase_q, phase_d;
  logic [6:0]    colour_q, colour_d;
  logic [CB-1:0] acc_q, acc_d;
  logic          in_run_q, in_run_d;
  logic [CB-1:0] pos_q, pos_d;
  logic [6:0]    prev_q, prev_d;

  logic [7:0]    b;
  logic          last;
  logic [CB-1:0] lim;
  logic          in_runs, start_run, zero_byte, run_active, do_run;
  logic [CB-1:0] add_base;
  logic [6:0]    add_bits;
  logic [CB+7:0] acc_sum;
  logic [CB-1:0] acc_sat;
  logic [6:0]    colour_cur;
  logic [CB:0]   len_raw;
  logic [CB-1:0] room, len;
  logic          run_emit, run_done, run_stop, fill_try, fill_emit;
  logic [CB-1:0] pos_run;
  logic [6:0]    prev_run;
  rrrld_pkg::out_item_t run_item, fill_item;

  assign b    = item_i.data_byte;
  assign last = item_i.row_end;
  assign lim  = (cfg_i.column_limit == '0) ? CB'(1) : cfg_i.column_limit;

  assign in_runs    = (phase_q == rrrld_pkg::PhRuns);
  assign start_run  = in_runs && !in_run_q && (b != 8'd0);
  assign zero_byte  = in_runs && !in_run_q && (b == 8'd0);
  assign run_active = in_runs && (in_run_q || (b != 8'd0));
  assign do_run     = run_active && (!b[7] || last);

  // count accumulation, 7 bits a byte, saturating at the limit
  assign add_base = in_run_q ? acc_q : '0;
  assign add_bits = in_run_q ? b[6:0] : (b[6:0] & (7'h7f >> cfg_i.colour_depth));
  assign acc_sum  = {1'b0, add_base, 7'd0} + {{(CB+1){1'b0}}, add_bits};
  assign acc_sat  = (acc_sum > {8'd0, lim}) ? lim : acc_sum[CB-1:0];

  assign colour_cur = start_run ? (b[6:0] >> (3'd7 - cfg_i.colour_depth)) : colour_q;

  // clip run to the remaining columns
  assign len_raw  = {1'b0, acc_sat} + {{CB{1'b0}}, 1'b1};
  assign room     = (lim > pos_q) ? (lim - pos_q) : '0;
  assign len      = (len_raw > {1'b0, room}) ? room : len_raw[CB-1:0];
  assign run_emit = do_run && (len != '0);
  assign run_done = ({1'b0, pos_q} + {1'b0, len}) >= {1'b0, lim};
  assign run_stop = do_run && (!run_emit || run_done);
  assign pos_run  = run_emit ? (pos_q + len) : pos_q;
  assign prev_run = run_emit ? colour_cur : prev_q;

  // fill to the limit with the last colour
  assign fill_try  = in_runs && !run_stop && (zero_byte || last);
  assign fill_emit = fill_try && (pos_run != '0) && (pos_run < lim);

  always_comb begin
    run_item.run_colour = colour_cur;
    run_item.run_start  = pos_q;
    run_item.run_length = len;
    run_item.is_fill    = 1'b0;
    run_item.row_done   = run_done;

    fill_item.run_colour = prev_run;
    fill_item.run_start  = pos_run;
    fill_item.run_length = lim - pos_run;
    fill_item.is_fill    = 1'b1;
    fill_item.row_done   = 1'b1;

    res_o.cnt    = fire_i ? ({1'b0, run_emit} + {1'b0, fill_emit}) : 2'd0;
    res_o.first  = run_emit ? run_item : fill_item;
    res_o.second = fill_item;
  end

  always_comb begin
    phase_d  = phase_q;
    colour_d = colour_q;
    acc_d    = acc_q;
    in_run_d = in_run_q;
    pos_d    = pos_q;
    prev_d   = prev_q;
    if (fire_i) begin
      if (last) begin
        phase_d  = rrrld_pkg::PhSkip;
        colour_d = '0;
        acc_d    = '0;
        in_run_d = 1'b0;
        pos_d    = '0;
        prev_d   = '0;
      end else begin
        case (phase_q)
          rrrld_pkg::PhSkip: begin
            if (!b[7]) phase_d = rrrld_pkg::PhRuns;
          end
          rrrld_pkg::PhRuns: begin
            acc_d    = do_run ? '0 : (run_active ? acc_sat : acc_q);
            in_run_d = run_active && !do_run;
            colour_d = colour_cur;
            pos_d    = pos_run;
            prev_d   = prev_run;
            if (run_stop || fill_try) phase_d = rrrld_pkg::PhDone;
          end
          rrrld_pkg::PhDone: begin
            phase_d = rrrld_pkg::PhDone;
          end
          default: begin
            phase_d = rrrld_pkg::PhSkip;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rrrld_pkg::PhSkip;
      colour_q <= '0;
      acc_q    <= '0;
      in_run_q <= 1'b0;
      pos_q    <= '0;
      prev_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      colour_q <= colour_d;
      acc_q    <= acc_d;
      in_run_q <= in_run_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
    end
  end

endmodule

// File: src/rrrld_out_fifo.sv
// ----------------------------------------------------------------------------
// rrrld_out_fifo
// result queue taking up to two beats a cycle and giving one unless the output stalls
// ----------------------------------------------------------------------------
module rrrld_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrrld_pkg::res_bundle_t push_i,
  output logic                   room2_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rrrld_pkg::out_item_t   out_data_o
);

  localparam int unsigned Depth = rrrld_pkg::FifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rrrld_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room2_o     = (count_q <= CntW'(Depth - 2));
  assign wr_ptr_nx   = wr_ptr_q + PtrW'(1);

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_nx] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/raster_row_run_length_decoder.sv
// path: an accepted input beat is registered, then decoded into the result queue
// throughput: one input beat per cycle while the queue has room for two beats;
// a row end may add a second result beat; the four-entry queue paces output stalls
// reset: asynchronous, active low; clears row state, queue and input register,
// colour depth to zero and column limit to 65535
// ----------------------------------------------------------------------------
// raster_row_run_length_decoder
// decodes compressed raster row bytes into coloured column runs
// ----------------------------------------------------------------------------
`include "raster_row_run_length_decoder_macros.svh"

module raster_row_run_length_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rrrld_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rrrld_pkg::out_item_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int unsigned CB = rrrld_pkg::ColumnBits;

  logic                   in_valid_q;
  rrrld_pkg::in_item_t    in_q;
  logic                   room2, fire;
  rrrld_pkg::cfg_t        cfg_q;
  rrrld_pkg::res_bundle_t res;

  assign cfg_ready_o = 1'b1;
  assign fire        = in_valid_q && room2;
  assign in_stall_o  = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colour_depth <= '0;
      cfg_q.column_limit <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rrrld_pkg::cfg_index_e'(cfg_index_i))
        rrrld_pkg::CfgColourDepth: cfg_q.colour_depth <= cfg_data_i[2:0];
        rrrld_pkg::CfgColumnLimit: cfg_q.column_limit <= cfg_data_i[CB-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_data_i;
  end

  rrrld_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  rrrld_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `RRRLD_ASSERT_IMP(a_fill_ends_row, clk_i, rst_ni, out_valid_o && out_data_o.is_fill, out_data_o.row_done)
  `RRRLD_ASSERT_IMP(a_run_nonzero, clk_i, rst_ni, out_valid_o, out_data_o.run_length != '0)
  `RRRLD_ASSERT_IMP(a_run_in_range, clk_i, rst_ni, out_valid_o, ({1'b0, out_data_o.run_start} + {1'b0, out_data_o.run_length}) <= {1'b0, {CB{1'b1}}})
  `RRRLD_ASSERT_NXT(a_held_beat, clk_i, rst_ni, in_stall_o, in_valid_q && $stable(in_q))

endmodule

// File: verif/raster_row_run_length_decoder_test.sv
// ----------------------------------------------------------------------------
// raster_row_run_length_decoder_test
// Drives compressed row bytes into the run-length decoder through a range of
// colour depths and column limits, including the smallest and largest. A
// short directed part is followed by random rows: most are well formed with
// random content, and some are cut short or are plain noise. Each run the
// block returns is checked field by field against a predictor in the
// scoreboard. The sender works in bursts with gaps between them, and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

class run_scoreboard;
  logic [2:0]          depth;
  logic [15:0]         limit_reg;
  rrrld_pkg::phase_e   phase;
  logic [6:0]          pend_colour;
  logic [6:0]          prev_colour;
  int unsigned         acc;
  int unsigned         pos;
  bit                  in_run;
  rrrld_pkg::out_item_t expected_runs[$];
  int unsigned         mismatches;

  function new();
    depth      = 3'd0;
    limit_reg  = 16'hffff;
    mismatches = 0;
    clear_row();
  endfunction

  function void clear_row();
    phase       = rrrld_pkg::PhSkip;
    pend_colour = '0;
    prev_colour = '0;
    acc         = 0;
    pos         = 0;
    in_run      = 1'b0;
  endfunction

  function void set_reg(rrrld_pkg::cfg_index_e idx, logic [15:0] val);
    if (idx == rrrld_pkg::CfgColourDepth) begin
      depth = val[2:0];
    end else begin
      limit_reg = val;
    end
  endfunction

  function int unsigned lim();
    return (limit_reg == 16'd0) ? 1 : int'(limit_reg);
  endfunction

  function void push_run(logic [6:0] colour, int unsigned start, int unsigned len,
                         bit fill, bit done);
    rrrld_pkg::out_item_t r;
    r.run_colour = colour;
    r.run_start  = 16'(start);
    r.run_length = 16'(len);
    r.is_fill    = fill;
    r.row_done   = done;
    expected_runs = {expected_runs, r};
  endfunction

  function void add_bits(int unsigned bits);
    acc = (acc << 7) + bits;
    if (acc > lim()) acc = lim();
  endfunction

  function void close_run();
    int unsigned l;
    int unsigned room;
    int unsigned len;
    bit          done;
    l    = lim();
    room = (l > pos) ? l - pos : 0;
    len  = acc + 1;
    if (len > room) len = room;
    acc    = 0;
    in_run = 1'b0;
    if (len == 0) begin
      phase = rrrld_pkg::PhDone;
      return;
    end
    done = (pos + len >= l);
    push_run(pend_colour, pos, len, 1'b0, done);
    pos         = pos + len;
    prev_colour = pend_colour;
    if (done) phase = rrrld_pkg::PhDone;
  endfunction

  function void close_with_fill();
    int unsigned l;
    l = lim();
    if (phase == rrrld_pkg::PhRuns && pos > 0 && pos < l) begin
      push_run(prev_colour, pos, l - pos, 1'b1, 1'b1);
      pos = l;
    end
    phase = rrrld_pkg::PhDone;
  endfunction

  function void note_byte(rrrld_pkg::in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    case (phase)
      rrrld_pkg::PhSkip: begin
        if (!b[7]) phase = rrrld_pkg::PhRuns;
      end
      rrrld_pkg::PhRuns: begin
        if (!in_run) begin
          if (b == 8'd0) begin
            close_with_fill();
          end else begin
            pend_colour = 7'(b[6:0] >> (3'd7 - depth));
            acc = 0;
            add_bits(b[6:0] & (7'h7f >> depth));
            if (b[7]) in_run = 1'b1;
            else close_run();
          end
        end else begin
          add_bits(b[6:0]);
          if (!b[7]) close_run();
        end
      end
      default: ;
    endcase
    if (it.row_end) begin
      if (phase == rrrld_pkg::PhRuns && in_run) close_run();
      if (phase == rrrld_pkg::PhRuns) close_with_fill();
      clear_row();
    end
  endfunction

  function void check_run(rrrld_pkg::out_item_t got);
    rrrld_pkg::out_item_t want;
    if (expected_runs.size() == 0) begin
      $error("unexpected run beat: colour %0d start %0d length %0d",
             got.run_colour, got.run_start, got.run_length);
      mismatches++;
      return;
    end
    want = expected_runs.pop_front();
    if (got.run_colour !== want.run_colour) begin
      $error("run_colour: expected %0d, got %0d", want.run_colour, got.run_colour);
      mismatches++;
    end
    if (got.run_start !== want.run_start) begin
      $error("run_start: expected %0d, got %0d", want.run_start, got.run_start);
      mismatches++;
    end
    if (got.run_length !== want.run_length) begin
      $error("run_length: expected %0d, got %0d", want.run_length, got.run_length);
      mismatches++;
    end
    if (got.is_fill !== want.is_fill) begin
      $error("is_fill: expected %0d, got %0d", want.is_fill, got.is_fill);
      mismatches++;
    end
    if (got.row_done !== want.row_done) begin
      $error("row_done: expected %0d, got %0d", want.row_done, got.row_done);
      mismatches++;
    end
  endfunction
endclass

module raster_row_run_length_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 8;

  localparam logic [8:0] DirectedBytes [21] = '{
    9'h081, 9'h001, 9'h07f, 9'h085, 9'h003, 9'h005, 9'h000, 9'h033, 9'h1ff,
    9'h180,
    9'h001, 9'h100,
    9'h001, 9'h185,
    9'h001, 9'h0ff, 9'h0ff, 9'h0ff, 9'h07f, 9'h012, 9'h100
  };

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  rrrld_pkg::in_item_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rrrld_pkg::out_item_t out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_index_i = 1'b0;
  logic [15:0]          cfg_data_i  = '0;

  run_scoreboard scoreboard = new();

  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned cycle_count = 0;

  raster_row_run_length_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("raster_row_run_length_decoder test failed");
      $finish;
    end
  end

  // result side: check accepted beats, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      scoreboard.check_run(out_data_o);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 60);
    end
    stall_left--;
    case (stall_mode)
      2:       out_stall_i <= ($urandom_range(0, 3) == 0);
      3:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b0;
    endcase
  end

  function automatic rrrld_pkg::in_item_t make_beat(logic [7:0] b, logic e);
    rrrld_pkg::in_item_t it;
    it.data_byte = b;
    it.row_end   = e;
    return it;
  endfunction

  task automatic send_beat(rrrld_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.note_byte(it);
    burst_left--;
  endtask

  task automatic write_reg(rrrld_pkg::cfg_index_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scoreboard.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (scoreboard.expected_runs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // row number, runs with random content, then one of several endings
  task automatic send_row(output int unsigned sent);
    rrrld_pkg::in_item_t row[$];
    int unsigned n_num;
    int unsigned n_runs;
    int unsigned n_cont;
    int unsigned ending;
    int unsigned cut;
    logic [6:0]  body;
    n_num = $urandom_range(0, 2);
    repeat (n_num) row = {row, make_beat({1'b1, 7'($urandom)}, 1'b0)};
    row = {row, make_beat({1'b0, 7'($urandom)}, 1'b0)};
    n_runs = $urandom_range(0, 8);
    repeat (n_runs) begin
      n_cont = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      body   = 7'($urandom);
      if (n_cont == 0 && body == 7'd0) body = 7'd1;
      row = {row, make_beat({n_cont != 0, body}, 1'b0)};
      for (int k = 0; k < int'(n_cont); k++) begin
        row = {row, make_beat({k < int'(n_cont) - 1, 7'($urandom)}, 1'b0)};
      end
    end
    ending = $urandom_range(0, 9);
    if (ending < 5) begin
      row = {row, make_beat(8'd0, 1'b0)};
      repeat ($urandom_range(0, 2)) row = {row, make_beat(8'($urandom), 1'b0)};
    end else if (ending == 8) begin
      cut = $urandom_range(0, row.size() - 1);
      while (row.size() > cut + 1) void'(row.pop_back());
    end else if (ending == 9) begin
      row = {};
      repeat ($urandom_range(1, 6)) row = {row, make_beat(8'($urandom), 1'b0)};
    end
    row[row.size() - 1].row_end = 1'b1;
    foreach (row[i]) send_beat(row[i]);
    sent = row.size();
  endtask

  task automatic run_phase(logic [2:0] d, logic [15:0] l, int unsigned budget);
    int unsigned sent;
    int unsigned n;
    wait_idle();
    write_reg(rrrld_pkg::CfgColourDepth, {13'd0, d});
    write_reg(rrrld_pkg::CfgColumnLimit, l);
    cfg_valid_i <= 1'b0;
    n = 0;
    while (n < budget) begin
      send_row(sent);
      n += sent;
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedBytes[i]) begin
      send_beat(make_beat(DirectedBytes[i][7:0], DirectedBytes[i][8]));
    end
    in_valid_i <= 1'b0;

    run_phase(3'd7, 16'd1, 100);
    run_phase(3'd0, 16'd65535, 150);
    run_phase(3'd3, 16'd20, 150);
    run_phase(3'd0, 16'd0, 60);
    run_phase(3'd5, 16'd100, 130);
    run_phase(3'd2, 16'd8, 130);
    run_phase(3'($urandom), 16'($urandom_range(2, 300)), 140);
    run_phase(3'($urandom), 16'($urandom_range(1, 65535)), 140);
    run_phase(3'd1, 16'd600, 100);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (scoreboard.mismatches == 0 && scoreboard.expected_runs.size() == 0) begin
      $display("raster_row_run_length_decoder test passed");
    end else begin
      $display("raster_row_run_length_decoder test failed");
    end
    $finish;
  end

endmodule
